// ===== rtl/bedf_pkg.sv =====
package bedf_pkg;

    typedef logic [7:0]         pix_t;
    typedef logic signed [8:0]  act_t;
    typedef logic [4:0]         step_t;

    localparam int unsigned NUM_PIX    = 10;
    localparam logic [1:0]  NEAR_THR   = 2'd2;
    localparam logic [3:0]  SMOOTH_CNT = 4'd6;
    localparam step_t       STEP_RESET = 5'd1;

    // analysis stage -> filter stage
    typedef struct packed {
        pix_t [NUM_PIX-1:0] pix;
        logic               half;
        logic [3:0]         cnt;
        act_t               a30;
        act_t               a31;
        act_t               a32;
        pix_t               mx;
        pix_t               mn;
        logic               sub_a;
        logic               sub_b;
    } bedf_s1_t;

    // filter stage -> output stage
    typedef struct packed {
        pix_t [8:1]         pix;
        logic               half;
        logic               smooth;
        logic               dflt;
        pix_t [8:1]         sm;
        logic signed [12:0] d5;
        act_t               lim;
    } bedf_s2_t;

    function automatic logic [8:0] abs_diff(input pix_t a, input pix_t b);
        logic [8:0] d;
        d = (a > b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
        return d;
    endfunction

    function automatic logic [11:0] ext12(input pix_t p);
        return {4'b0000, p};
    endfunction

    // (2*(a-d) - 5*(b-c) + 4) / 8, truncating toward zero
    function automatic act_t activity(input pix_t a, input pix_t b,
                                      input pix_t c, input pix_t d);
        logic signed [11:0] sum;
        logic signed [11:0] q;
        sum = 12'sd2 * ($signed(ext12(a)) - $signed(ext12(d)))
            - 12'sd5 * ($signed(ext12(b)) - $signed(ext12(c))) + 12'sd4;
        q = sum[11] ? ((sum + 12'sd7) >>> 3) : (sum >>> 3);
        return q[8:0];
    endfunction

    function automatic logic [8:0] abs_act(input act_t a);
        logic [8:0] r;
        r = a[8] ? 9'(-a) : 9'(a);
        return r;
    endfunction

endpackage

// ===== rtl/bedf_analyze.sv =====
module bedf_analyze
    import bedf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  pix_t [NUM_PIX-1:0]  pix,
    input  logic                half,
    input  step_t               step,
    output logic                out_vld,
    output bedf_s1_t            s1
);

    logic     vld_reg;
    bedf_s1_t s1_reg;
    bedf_s1_t s1_next;

    always_comb
    begin
        logic [3:0] cnt;
        pix_t       mx;
        pix_t       mn;
        cnt = 4'd0;
        for (int i = 0; i < NUM_PIX - 1; i++)
        begin
            if (abs_diff(pix[i], pix[i+1]) <= {7'd0, NEAR_THR})
                cnt = cnt + 4'd1;
        end
        mx = pix[1];
        mn = pix[1];
        for (int i = 2; i <= 8; i++)
        begin
            if (pix[i] > mx)
                mx = pix[i];
            if (pix[i] < mn)
                mn = pix[i];
        end
        s1_next.pix   = pix;
        s1_next.half  = half;
        s1_next.cnt   = cnt;
        s1_next.a30   = activity(pix[3], pix[4], pix[5], pix[6]);
        s1_next.a31   = activity(pix[1], pix[2], pix[3], pix[4]);
        s1_next.a32   = activity(pix[5], pix[6], pix[7], pix[8]);
        s1_next.mx    = mx;
        s1_next.mn    = mn;
        // end pixel replaced by its inner neighbor on a step-sized jump
        s1_next.sub_a = abs_diff(pix[1], pix[0]) >= {4'd0, step};
        s1_next.sub_b = abs_diff(pix[8], pix[9]) >= {4'd0, step};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
            s1_reg <= s1_next;
    end

    assign out_vld = vld_reg;
    assign s1      = s1_reg;

endmodule

// ===== rtl/bedf_filter.sv =====
module bedf_filter
    import bedf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  bedf_s1_t    s1,
    input  step_t       step,
    output logic        out_vld,
    output bedf_s2_t    s2
);

    logic     vld_reg;
    bedf_s2_t s2_reg;
    bedf_s2_t s2_next;

    always_comb
    begin
        logic [8:0]         range;
        logic               flat;
        logic               many;
        logic [11:0]        ea;
        logic [11:0]        eb;
        logic [11:0]        v1, v2, v3, v4, v5, v6, v7, v8;
        logic [11:0]        sum [8:1];
        logic [8:0]         abs30;
        logic [8:0]         abs31;
        logic [8:0]         abs32;
        logic [8:0]         m;
        logic signed [9:0]  mm;
        logic signed [9:0]  da;
        logic signed [8:0]  diff;

        range = {1'b0, s1.mx} - {1'b0, s1.mn};
        flat  = range < {3'd0, step, 1'b0};
        many  = s1.cnt >= SMOOTH_CNT;

        ea = ext12(s1.sub_a ? s1.pix[1] : s1.pix[0]);
        eb = ext12(s1.sub_b ? s1.pix[8] : s1.pix[9]);
        v1 = ext12(s1.pix[1]);
        v2 = ext12(s1.pix[2]);
        v3 = ext12(s1.pix[3]);
        v4 = ext12(s1.pix[4]);
        v5 = ext12(s1.pix[5]);
        v6 = ext12(s1.pix[6]);
        v7 = ext12(s1.pix[7]);
        v8 = ext12(s1.pix[8]);

        sum[1] = 12'd6*ea + 12'd4*v1 + 12'd2*v2 + 12'd2*v3 + v4 + v5 + 12'd8;
        sum[2] = 12'd4*ea + 12'd2*v1 + 12'd4*v2 + 12'd2*v3 + 12'd2*v4 + v5 + v6 + 12'd8;
        sum[3] = 12'd2*ea + 12'd2*v1 + 12'd2*v2 + 12'd4*v3 + 12'd2*v4 + 12'd2*v5
               + v6 + v7 + 12'd8;
        sum[4] = ea + v1 + 12'd2*v2 + 12'd2*v3 + 12'd4*v4 + 12'd2*v5 + 12'd2*v6
               + v7 + v8 + 12'd8;
        sum[5] = v1 + v2 + 12'd2*v3 + 12'd2*v4 + 12'd4*v5 + 12'd2*v6 + 12'd2*v7
               + v8 + eb + 12'd8;
        sum[6] = v2 + v3 + 12'd2*v4 + 12'd2*v5 + 12'd4*v6 + 12'd2*v7 + 12'd2*v8
               + 12'd2*eb + 12'd8;
        sum[7] = v3 + v4 + 12'd2*v5 + 12'd2*v6 + 12'd4*v7 + 12'd2*v8 + 12'd4*eb + 12'd8;
        sum[8] = v4 + v5 + 12'd2*v6 + 12'd2*v7 + 12'd4*v8 + 12'd6*eb + 12'd8;

        abs30 = abs_act(s1.a30);
        abs31 = abs_act(s1.a31);
        abs32 = abs_act(s1.a32);
        m     = (abs31 < abs32) ? abs31 : abs32;
        mm    = $signed({1'b0, m});
        da    = (s1.a30[8] ? -mm : mm) - $signed({s1.a30[8], s1.a30});
        diff  = $signed({1'b0, s1.pix[4]}) - $signed({1'b0, s1.pix[5]});

        s2_next.pix    = s1.pix[8:1];
        s2_next.half   = s1.half;
        s2_next.smooth = many && flat;
        s2_next.dflt   = !many && (abs30 < {4'd0, step}) && (m < abs30);
        for (int i = 1; i <= 8; i++)
            s2_next.sm[i] = sum[i][11:4];
        s2_next.d5     = $signed({{3{da[9]}}, da}) * 13'sd5;
        s2_next.lim    = diff[8] ? ((diff + 9'sd1) >>> 1) : (diff >>> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
            s2_reg <= s2_next;
    end

    assign out_vld = vld_reg;
    assign s2      = s2_reg;

endmodule

// ===== rtl/bedf_output.sv =====
module bedf_output
    import bedf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  bedf_s2_t    s2,
    output logic        out_vld,
    output pix_t [8:1]  res
);

    logic       vld_reg;
    pix_t [8:1] res_reg;
    pix_t [8:1] res_next;

    function automatic pix_t clip(input logic signed [10:0] a);
        pix_t r;
        if (a < 0)
            r = 8'd0;
        else if (a > 11'sd255)
            r = 8'd255;
        else
            r = a[7:0];
        return r;
    endfunction

    always_comb
    begin
        logic signed [12:0] q;
        logic signed [9:0]  d;
        logic signed [9:0]  lim;
        logic signed [10:0] r4;
        logic signed [10:0] r5;

        q   = s2.d5[12] ? ((s2.d5 + 13'sd7) >>> 3) : (s2.d5 >>> 3);
        d   = q[9:0];
        lim = {s2.lim[8], s2.lim};
        if (lim > 0)
        begin
            if (d < 0)
                d = 10'sd0;
            if (d > lim)
                d = lim;
        end
        else
        begin
            if (d > 0)
                d = 10'sd0;
            if (d < lim)
                d = lim;
        end
        r4 = $signed({3'b000, s2.pix[4]}) - {d[9], d};
        r5 = $signed({3'b000, s2.pix[5]}) + {d[9], d};

        res_next = s2.pix;
        if (s2.smooth)
        begin
            for (int i = 1; i <= 4; i++)
                res_next[i] = s2.sm[i];
            if (!s2.half)
            begin
                for (int i = 5; i <= 8; i++)
                    res_next[i] = s2.sm[i];
            end
        end
        else if (s2.dflt)
        begin
            res_next[4] = clip(r4);
            if (!s2.half)
                res_next[5] = clip(r5);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
            res_reg <= res_next;
    end

    assign out_vld = vld_reg;
    assign res     = res_reg;

endmodule

// ===== rtl/block_edge_deblock_filter.sv =====
// Deblocking filter for one line of ten pixels across a block edge
// (edge between pix_4 and pix_5); returns filtered pixels out_1..out_8.
//
// Input: drive pix_0..pix_9 and mode with start high; the line is
// transferred at a clock edge where start is high and busy is low. busy
// is always low, so a new line may be transferred every cycle.
// Output: once the line has passed the analysis, filter and output registers,
// done is high for exactly one cycle with out_1..out_8 valid. The receiver
// has no hold-off; results come out in input order, one per cycle at full rate.
// Pipeline: analysis (neighbor counts, max/min, activity), filter taps and
// correction terms, then selection/clipping into the output register.
// Throughput is one line per clock.
// Configuration: cfg_we writes cfg_data into the step size register; change
// it only while no line is in flight.
// Reset: clears the pipeline valid bits (no done pulses) and sets the step
// size to 1.
module block_edge_deblock_filter
    import bedf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  pix_t  pix_0,
    input  pix_t  pix_1,
    input  pix_t  pix_2,
    input  pix_t  pix_3,
    input  pix_t  pix_4,
    input  pix_t  pix_5,
    input  pix_t  pix_6,
    input  pix_t  pix_7,
    input  pix_t  pix_8,
    input  pix_t  pix_9,
    input  logic  mode,
    input  logic  cfg_we,
    input  step_t cfg_data,
    output logic  done,
    output pix_t  out_1,
    output pix_t  out_2,
    output pix_t  out_3,
    output pix_t  out_4,
    output pix_t  out_5,
    output pix_t  out_6,
    output pix_t  out_7,
    output pix_t  out_8
);

    step_t              step_reg;
    pix_t [NUM_PIX-1:0] pix;
    logic               s1_vld;
    bedf_s1_t           s1;
    logic               s2_vld;
    bedf_s2_t           s2;
    pix_t [8:1]         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_data;
    end

    assign busy = 1'b0;
    assign pix  = {pix_9, pix_8, pix_7, pix_6, pix_5, pix_4, pix_3, pix_2, pix_1, pix_0};

    bedf_analyze u_analyze (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .pix     (pix),
        .half    (mode),
        .step    (step_reg),
        .out_vld (s1_vld),
        .s1      (s1)
    );

    bedf_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s1_vld),
        .s1      (s1),
        .step    (step_reg),
        .out_vld (s2_vld),
        .s2      (s2)
    );

    bedf_output u_output (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s2_vld),
        .s2      (s2),
        .out_vld (done),
        .res     (res)
    );

    assign out_1 = res[1];
    assign out_2 = res[2];
    assign out_3 = res[3];
    assign out_4 = res[4];
    assign out_5 = res[5];
    assign out_6 = res[6];
    assign out_7 = res[7];
    assign out_8 = res[8];

endmodule

// ===== rtl/bedf_checker.sv =====
module bedf_props
    import bedf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  pix_t pix_5,
    input  pix_t pix_6,
    input  pix_t pix_7,
    input  pix_t pix_8,
    input  logic mode,
    input  logic done,
    input  pix_t out_5,
    input  pix_t out_6,
    input  pix_t out_7,
    input  pix_t out_8
);

    // every transferred line yields its result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("missing result three cycles after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching transfer");

    // half edge never touches the far side
    a_half_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |-> ##3
            (out_5 == $past(pix_5, 3) && out_6 == $past(pix_6, 3) &&
             out_7 == $past(pix_7, 3) && out_8 == $past(pix_8, 3)))
        else $error("half edge changed pixels 5..8");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a fully pipelined block");

endmodule

bind block_edge_deblock_filter bedf_props u_bedf_props (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .pix_5 (pix_5),
    .pix_6 (pix_6),
    .pix_7 (pix_7),
    .pix_8 (pix_8),
    .mode  (mode),
    .done  (done),
    .out_5 (out_5),
    .out_6 (out_6),
    .out_7 (out_7),
    .out_8 (out_8)
);
